[rtl/pcdt_pkg.sv]
// Types, constants and the tolerance compare shared by the plane component dedup table.
// No dependencies.
`default_nettype none

package pcdt_pkg;

    localparam int VALUE_BITS = 32;
    localparam int EPS_BITS   = 16;
    localparam int NUM_LANES  = 4;
    localparam int REQ_BITS   = 2;

    localparam logic [REQ_BITS-1:0] REQ_FIND  = 2'd0;
    localparam logic [REQ_BITS-1:0] REQ_ADD   = 2'd1;
    localparam logic [REQ_BITS-1:0] REQ_CLEAR = 2'd2;

    localparam logic [EPS_BITS-1:0] EPS_RESET = 16'd7;

    typedef logic signed [VALUE_BITS-1:0] value_t;

    typedef struct packed {
        logic [REQ_BITS-1:0] req_type;
        value_t              normal_x;
        value_t              normal_y;
        value_t              normal_z;
        value_t              plane_distance;
    } plane_req_t;

    typedef struct packed {
        logic   found;
        value_t snapped_x;
        value_t snapped_y;
        value_t snapped_z;
        value_t snapped_distance;
        logic   overflow;
    } plane_res_t;

    typedef struct packed {
        logic load;
        logic scan;
        logic finish;
    } pcdt_cmd_t;

    typedef struct packed {
        logic scan_done;
    } pcdt_sts_t;

    typedef enum logic [2:0] {
        ST_IDLE   = 3'b001,
        ST_SCAN   = 3'b010,
        ST_FINISH = 3'b100
    } pcdt_state_t;

    // |a - b| < eps, difference formed one bit wider so nothing wraps
    function automatic logic value_match(input value_t a, input value_t b,
                                         input logic [EPS_BITS-1:0] eps);
        logic signed [VALUE_BITS:0] diff;
        logic [VALUE_BITS:0]        mag;
        diff = $signed({a[VALUE_BITS-1], a}) - $signed({b[VALUE_BITS-1], b});
        mag  = diff[VALUE_BITS] ? (VALUE_BITS+1)'(-diff) : (VALUE_BITS+1)'(diff);
        return mag < {{(VALUE_BITS+1-EPS_BITS){1'b0}}, eps};
    endfunction

endpackage

`default_nettype wire

[rtl/plane_component_dedup_table.sv]
// The done strobe follows a scan of N entries after start is taken, N being the largest fill
// count of the four tables; clear and the unused code skip the scan.
// One item is taken at a time: busy stays high until it drops in the cycle of the strobe.
// The scan reads each table RAM through its single read port, one entry per cycle.
// Reset: fill counts clear at once, epsilon returns to 7, table contents stay undefined.
// Top level: joins pcdt_ctrl and pcdt_datapath; depends on pcdt_pkg.
`default_nettype none

module plane_component_dedup_table #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire pcdt_pkg::plane_req_t          req,
    input  wire logic                          cfg_we,
    input  wire logic [pcdt_pkg::EPS_BITS-1:0] cfg_wdata,
    output logic                               done,
    output pcdt_pkg::plane_res_t               result
);

    import pcdt_pkg::*;

    pcdt_cmd_t cmd;
    pcdt_sts_t sts;

    pcdt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    pcdt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .done      (done),
        .result    (result)
    );

endmodule

`default_nettype wire

[rtl/pcdt_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
`default_nettype none

module pcdt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/pcdt_ctrl.sv]
// Controller FSM for the plane component dedup table.
// Depends on pcdt_pkg.
`default_nettype none

module pcdt_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire pcdt_pkg::pcdt_sts_t sts,
    output pcdt_pkg::pcdt_cmd_t     cmd,
    output logic                    busy
);

    import pcdt_pkg::*;

    pcdt_state_t state_reg;
    pcdt_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sts.scan_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy       = (state_reg != ST_IDLE);
    assign cmd.load   = (state_reg == ST_IDLE) && start;
    assign cmd.scan   = (state_reg == ST_SCAN);
    assign cmd.finish = (state_reg == ST_FINISH);

endmodule

`default_nettype wire

[rtl/pcdt_datapath.sv]
// Datapath: four component tables, fill counts, scan pointer, match flags and result register.
// Depends on pcdt_pkg and pcdt_ram.
`default_nettype none

module pcdt_datapath #(
    parameter int TABLE_DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire pcdt_pkg::pcdt_cmd_t      cmd,
    output pcdt_pkg::pcdt_sts_t           sts,
    input  wire pcdt_pkg::plane_req_t     req,
    input  wire logic                     cfg_we,
    input  wire logic [pcdt_pkg::EPS_BITS-1:0] cfg_wdata,
    output logic                          done,
    output pcdt_pkg::plane_res_t          result
);

    import pcdt_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

    plane_req_t          in_reg;
    logic [EPS_BITS-1:0] eps_reg;
    logic [CW-1:0]       count_reg [NUM_LANES];
    logic [CW-1:0]       count_next [NUM_LANES];
    logic [CW-1:0]       scan_idx_reg;
    logic [CW-1:0]       scan_len_reg;
    logic [CW-1:0]       scan_len_next;
    logic [CW-1:0]       rd_idx_reg;
    logic                rd_vld_reg;
    logic                rd_vld_next;
    logic [NUM_LANES-1:0] hit_reg;
    logic [NUM_LANES-1:0] hit_next;
    value_t              hit_val_reg [NUM_LANES];
    logic                done_reg;
    plane_res_t          result_reg;
    plane_res_t          result_next;

    value_t              in_val [NUM_LANES];
    value_t              rdata [NUM_LANES];
    logic [NUM_LANES-1:0] wr_en;
    logic                issue_done;
    logic                is_find;
    logic                is_add;
    logic                is_clear;
    logic                any_full_miss;
    value_t              snap [NUM_LANES];

    assign in_val[0] = in_reg.normal_x;
    assign in_val[1] = in_reg.normal_y;
    assign in_val[2] = in_reg.normal_z;
    assign in_val[3] = in_reg.plane_distance;

    assign is_find  = (in_reg.req_type == REQ_FIND);
    assign is_add   = (in_reg.req_type == REQ_ADD);
    assign is_clear = (in_reg.req_type == REQ_CLEAR);

    assign issue_done    = (scan_idx_reg == scan_len_reg);
    assign rd_vld_next   = cmd.scan && !issue_done;
    assign sts.scan_done = issue_done && !rd_vld_reg;

    // scan length: largest fill count, or nothing for clear and unused codes
    always_comb
    begin
        scan_len_next = '0;
        if ((req.req_type == REQ_FIND) || (req.req_type == REQ_ADD))
        begin
            for (int l = 0; l < NUM_LANES; l++)
            begin
                if (count_reg[l] > scan_len_next)
                begin
                    scan_len_next = count_reg[l];
                end
            end
        end
    end

    generate
        for (genvar g = 0; g < NUM_LANES; g++)
        begin : g_lane
            pcdt_ram #(
                .WIDTH (VALUE_BITS),
                .DEPTH (TABLE_DEPTH)
            ) u_table (
                .clk   (clk),
                .we    (wr_en[g]),
                .waddr (count_reg[g][AW-1:0]),
                .wdata (in_val[g]),
                .raddr (scan_idx_reg[AW-1:0]),
                .rdata (rdata[g])
            );
        end
    endgenerate

    always_comb
    begin
        any_full_miss = 1'b0;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            hit_next[l] = hit_reg[l];
            if (rd_vld_reg && !hit_reg[l] && (rd_idx_reg < count_reg[l])
                && value_match(rdata[l], in_val[l], eps_reg))
            begin
                hit_next[l] = 1'b1;
            end
            snap[l]  = hit_reg[l] ? hit_val_reg[l] : in_val[l];
            wr_en[l] = cmd.finish && is_add && !hit_reg[l] && (count_reg[l] != DEPTH_C);
            if (!hit_reg[l] && (count_reg[l] == DEPTH_C))
            begin
                any_full_miss = 1'b1;
            end
            count_next[l] = count_reg[l];
            if (cmd.finish && is_clear)
            begin
                count_next[l] = '0;
            end
            else if (wr_en[l])
            begin
                count_next[l] = count_reg[l] + CW'(1);
            end
        end
    end

    always_comb
    begin
        result_next = '0;
        if (is_find || is_add)
        begin
            result_next.found            = is_add || (&hit_reg);
            result_next.snapped_x        = snap[0];
            result_next.snapped_y        = snap[1];
            result_next.snapped_z        = snap[2];
            result_next.snapped_distance = snap[3];
            result_next.overflow         = is_add && any_full_miss;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg      <= EPS_RESET;
            scan_idx_reg <= '0;
            scan_len_reg <= '0;
            rd_vld_reg   <= 1'b0;
            hit_reg      <= '0;
            done_reg     <= 1'b0;
            for (int l = 0; l < NUM_LANES; l++)
            begin
                count_reg[l] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                eps_reg <= cfg_wdata;
            end
            if (cmd.load)
            begin
                scan_idx_reg <= '0;
                scan_len_reg <= scan_len_next;
                hit_reg      <= '0;
            end
            else
            begin
                hit_reg <= hit_next;
                if (rd_vld_next)
                begin
                    scan_idx_reg <= scan_idx_reg + CW'(1);
                end
            end
            rd_vld_reg <= rd_vld_next;
            done_reg   <= cmd.finish;
            for (int l = 0; l < NUM_LANES; l++)
            begin
                count_reg[l] <= count_next[l];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            in_reg <= req;
        end
        rd_idx_reg <= scan_idx_reg;
        for (int l = 0; l < NUM_LANES; l++)
        begin
            if (hit_next[l] && !hit_reg[l])
            begin
                hit_val_reg[l] <= rdata[l];
            end
        end
        if (cmd.finish)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

[rtl/pcdt_checker.sv]
// Port-level assertions for the plane component dedup table, bound to the top level.
// Depends on pcdt_pkg and plane_component_dedup_table.
`default_nettype none

module pcdt_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          start,
    input wire logic                          busy,
    input wire pcdt_pkg::plane_req_t          req,
    input wire logic                          done,
    input wire pcdt_pkg::plane_res_t          result
);

    import pcdt_pkg::*;

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted item");

    a_done_single: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("done strobe longer than one cycle");

    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while still busy");

    a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (req.req_type != REQ_FIND) && (req.req_type != REQ_ADD))
        |-> ##3 (done && !result.found && !result.overflow))
        else $error("clear or unused request gave a wrong or late result");

    a_overflow_add: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.overflow) |-> result.found)
        else $error("overflow flagged outside an add");

endmodule

bind plane_component_dedup_table pcdt_checker u_pcdt_checker (.*);

`default_nettype wire

[tb/plane_component_dedup_table_tb.sv]
// Self-checking testbench for plane_component_dedup_table: directed and random find/add/clear
// items against a shadow copy of the four value tables and the match tolerance.
// Depends on pcdt_pkg and the block's RTL.
`timescale 1ns / 1ps

module plane_component_dedup_table_tb;

    import pcdt_pkg::*;

    localparam int TABLE_DEPTH    = 64;
    localparam int POOL_DEPTH     = 128;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int TAIL_CYCLES    = 100;
    localparam int MAX_GAP        = 18;

    localparam logic [REQ_BITS-1:0] REQ_UNUSED = 2'd3;

    localparam value_t VMIN = 32'sh8000_0000;
    localparam value_t VMAX = 32'sh7fff_ffff;

    typedef enum int {
        GAPS_RANDOM,
        GAPS_NONE,
        GAPS_SPARSE
    } gap_mode_t;

    typedef struct {
        plane_req_t  plane;
        int unsigned gap;
    } pend_item_t;

    logic                clk;
    logic                rst_n;
    logic                start;
    logic                busy;
    plane_req_t          req;
    logic                cfg_we;
    logic [EPS_BITS-1:0] cfg_wdata;
    logic                done;
    plane_res_t          result;

    pend_item_t pending_items[$];
    plane_res_t expected_planes[$];

    // shadow state of the block
    value_t              shadow_tab [4][TABLE_DEPTH];
    int                  shadow_cnt [4];
    logic [EPS_BITS-1:0] shadow_eps;

    // stimulus-side memory of values, used to aim near stored entries
    value_t      val_pool [4][POOL_DEPTH];
    int          pool_fill [4];
    int          pool_wr [4];
    int unsigned gen_eps;
    gap_mode_t   gap_mode;

    int          n_issued;
    int          n_accepted;
    int          fail_count;
    int          idle_cycles;
    logic        drv_have;
    pend_item_t  drv_cur;
    int unsigned drv_wait;
    plane_res_t  want_res;

    plane_component_dedup_table #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .busy     (busy),
        .req      (req),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .done     (done),
        .result   (result)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic plane_res_t dedup_predict(input plane_req_t r);
        plane_res_t res;
        value_t     vin [4];
        value_t     snap [4];
        logic       all_hit;
        logic       hit;
        longint     d;
        res = '0;
        if (r.req_type == REQ_CLEAR)
        begin
            for (int c = 0; c < 4; c++)
                shadow_cnt[c] = 0;
            return res;
        end
        if (r.req_type == REQ_UNUSED)
            return res;
        vin[0]  = r.normal_x;
        vin[1]  = r.normal_y;
        vin[2]  = r.normal_z;
        vin[3]  = r.plane_distance;
        all_hit = 1'b1;
        for (int c = 0; c < 4; c++)
        begin
            hit     = 1'b0;
            snap[c] = vin[c];
            for (int i = 0; i < shadow_cnt[c] && !hit; i++)
            begin
                d = longint'(shadow_tab[c][i]) - longint'(vin[c]);
                if (d < 0)
                    d = -d;
                if (d < longint'(shadow_eps))
                begin
                    hit     = 1'b1;
                    snap[c] = shadow_tab[c][i];
                end
            end
            if (!hit)
            begin
                all_hit = 1'b0;
                if (r.req_type == REQ_ADD)
                begin
                    if (shadow_cnt[c] < TABLE_DEPTH)
                    begin
                        shadow_tab[c][shadow_cnt[c]] = vin[c];
                        shadow_cnt[c]++;
                    end
                    else
                        res.overflow = 1'b1;
                end
            end
        end
        res.found            = (r.req_type == REQ_ADD) ? 1'b1 : all_hit;
        res.snapped_x        = snap[0];
        res.snapped_y        = snap[1];
        res.snapped_z        = snap[2];
        res.snapped_distance = snap[3];
        return res;
    endfunction

    function automatic value_t pick_value(input int c);
        int unsigned sel;
        int unsigned span;
        value_t      v;
        sel  = $urandom_range(0, 99);
        span = gen_eps + 2;
        if (sel < 10)
        begin
            case ($urandom_range(0, 3))
                0:       v = VMIN;
                1:       v = VMAX;
                2:       v = '0;
                default: v = '1;
            endcase
        end
        else if (sel < 40 || pool_fill[c] == 0)
            v = $urandom;
        else
        begin
            v = val_pool[c][$urandom_range(0, pool_fill[c] - 1)];
            v = v + value_t'($urandom_range(0, 2 * span)) - value_t'(span);
        end
        val_pool[c][pool_wr[c]] = v;
        pool_wr[c] = (pool_wr[c] + 1) % POOL_DEPTH;
        if (pool_fill[c] < POOL_DEPTH)
            pool_fill[c]++;
        return v;
    endfunction

    function automatic int unsigned draw_gap();
        case (gap_mode)
            GAPS_NONE:   return 0;
            GAPS_SPARSE: return ($urandom_range(0, 3) == 0) ? $urandom_range(0, MAX_GAP) : 0;
            default:     return $urandom_range(0, MAX_GAP);
        endcase
    endfunction

    task automatic push_plane(input logic [REQ_BITS-1:0] rt, input value_t x, input value_t y,
                              input value_t z, input value_t d);
        pend_item_t it;
        it.plane.req_type       = rt;
        it.plane.normal_x       = x;
        it.plane.normal_y       = y;
        it.plane.normal_z       = z;
        it.plane.plane_distance = d;
        it.gap                  = draw_gap();
        pending_items.insert(pending_items.size(), it);
    endtask

    task automatic wait_drained();
        while (!(pending_items.size() == 0 && !drv_have && n_accepted == n_issued
                 && expected_planes.size() == 0))
            @(posedge clk);
    endtask

    task automatic run_phase(input int unsigned eps, input int unsigned clear_pct,
                             input gap_mode_t mode, input int n);
        int unsigned sel;
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= eps[EPS_BITS-1:0];
        @(negedge clk);
        cfg_we    <= 1'b0;
        gen_eps  = eps;
        gap_mode = mode;
        for (int k = 0; k < n; k++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < clear_pct)
                push_plane(REQ_CLEAR, $urandom, $urandom, $urandom, $urandom);
            else if (sel < clear_pct + 3)
                push_plane(REQ_UNUSED, $urandom, $urandom, $urandom, $urandom);
            else if (sel < 55)
                push_plane(REQ_ADD, pick_value(0), pick_value(1), pick_value(2), pick_value(3));
            else
                push_plane(REQ_FIND, pick_value(0), pick_value(1), pick_value(2), pick_value(3));
        end
        wait_drained();
    endtask

    task automatic check_field(input string fname, input logic [31:0] exp_v,
                               input logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, fname, exp_v, act_v);
            fail_count++;
        end
    endtask

    // driver: one item in flight on start, held until taken
    always @(negedge clk)
    begin
        if (rst_n && !(start && n_accepted != n_issued))
        begin
            if (!drv_have && pending_items.size() > 0)
            begin
                drv_cur  = pending_items.pop_front();
                drv_wait = drv_cur.gap;
                drv_have = 1'b1;
            end
            if (drv_have && drv_wait == 0)
            begin
                start    <= 1'b1;
                req      <= drv_cur.plane;
                n_issued++;
                drv_have = 1'b0;
            end
            else
            begin
                start <= 1'b0;
                if (drv_have)
                    drv_wait--;
            end
        end
    end

    // monitor: predict on accept, check on done, watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                shadow_eps = cfg_wdata;
            if (done)
            begin
                if (expected_planes.size() == 0)
                begin
                    $display("%0t: result with no item pending, actual %h", $time, result);
                    fail_count++;
                end
                else
                begin
                    want_res = expected_planes.pop_front();
                    check_field("found", {31'b0, want_res.found}, {31'b0, result.found});
                    check_field("snapped_x", want_res.snapped_x, result.snapped_x);
                    check_field("snapped_y", want_res.snapped_y, result.snapped_y);
                    check_field("snapped_z", want_res.snapped_z, result.snapped_z);
                    check_field("snapped_distance", want_res.snapped_distance,
                                result.snapped_distance);
                    check_field("overflow", {31'b0, want_res.overflow}, {31'b0, result.overflow});
                end
            end
            if (start && !busy)
            begin
                expected_planes.insert(expected_planes.size(), dedup_predict(req));
                n_accepted++;
            end
            if (done || cfg_we || (start && !busy))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        clk         = 1'b0;
        rst_n       = 1'b0;
        start       = 1'b0;
        req         = '0;
        cfg_we      = 1'b0;
        cfg_wdata   = '0;
        n_issued    = 0;
        n_accepted  = 0;
        fail_count  = 0;
        idle_cycles = 0;
        drv_have    = 1'b0;
        drv_wait    = 0;
        shadow_eps  = EPS_RESET;
        gen_eps     = EPS_RESET;
        gap_mode    = GAPS_RANDOM;
        for (int c = 0; c < 4; c++)
        begin
            shadow_cnt[c] = 0;
            pool_fill[c]  = 0;
            pool_wr[c]    = 0;
        end

        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // directed, reset tolerance of 7
        push_plane(REQ_FIND, '0, '0, '0, '0);
        push_plane(REQ_ADD, VMIN, VMAX, '0, '1);
        push_plane(REQ_FIND, VMIN, VMAX, '0, '1);
        push_plane(REQ_FIND, VMIN + 6, VMAX - 6, 32'sd6, -32'sd7);
        push_plane(REQ_FIND, VMIN + 7, VMAX, '0, '1);
        push_plane(REQ_ADD, 32'sd7, VMAX - 7, -32'sd6, 32'sd5);
        push_plane(REQ_FIND, VMAX, VMIN, VMAX, VMIN);
        push_plane(REQ_ADD, $urandom, $urandom, $urandom, $urandom);
        push_plane(REQ_UNUSED, '1, '1, '1, '1);
        push_plane(REQ_CLEAR, '1, '1, '1, '1);
        push_plane(REQ_FIND, VMIN, VMAX, '0, '1);
        push_plane(REQ_ADD, 32'sd1, 32'sd2, 32'sd3, 32'sd4);
        push_plane(REQ_FIND, 32'sd1, 32'sd2, 32'sd3, 32'sd4);
        push_plane(REQ_ADD, 32'sd8, 32'sd9, 32'sd10, 32'sd11);
        push_plane(REQ_FIND, 32'sd8, 32'sd2, 32'sd10, 32'sd4);
        wait_drained();

        run_phase(0, 0, GAPS_RANDOM, 150);
        run_phase(16'hffff, 3, GAPS_RANDOM, 120);
        run_phase(1, 2, GAPS_NONE, 120);
        run_phase($urandom_range(0, 16'hffff), 4, GAPS_SPARSE, 120);
        run_phase($urandom_range(2, 300), 0, GAPS_RANDOM, 180);
        run_phase(EPS_RESET, 5, GAPS_SPARSE, 160);

        repeat (TAIL_CYCLES) @(posedge clk);
        if (expected_planes.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, expected_planes.size());
            fail_count += expected_planes.size();
        end
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

[files.f]
rtl/pcdt_pkg.sv
rtl/pcdt_ram.sv
rtl/pcdt_ctrl.sv
rtl/pcdt_datapath.sv
rtl/plane_component_dedup_table.sv
rtl/pcdt_checker.sv
tb/plane_component_dedup_table_tb.sv
